// File: rtl/core/alc_pkg.sv
// alc_pkg: shared types and constants for the assembly line classifier
// depends on nothing; imported by alc_scanner, asm_line_classifier and the testbench
package alc_pkg;

    localparam int OFFSET_BITS = 32;
    localparam int LINE_BITS   = 28;
    localparam int NUM_BITS    = LINE_BITS + 1;
    localparam logic [NUM_BITS-1:0] LINE_MAX = 29'h1000_0000;

    localparam logic [31:0] HASH_INIT  = 32'h811C_9DC5;
    localparam logic [31:0] HASH_PRIME = 32'h0100_0193;

    localparam logic [7:0] CH_COLON   = 8'h3A;
    localparam logic [7:0] CH_HASH    = 8'h23;
    localparam logic [7:0] CH_DOT     = 8'h2E;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_SLASH   = 8'h2F;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_DOLLAR  = 8'h24;
    localparam logic [7:0] CH_UNDER   = 8'h5F;

    typedef enum logic [1:0] {
        PH_INDENT = 2'd0,
        PH_SYMBOL = 2'd1,
        PH_SLASH  = 2'd2,
        PH_REST   = 2'd3
    } phase_t;

    typedef enum logic [2:0] {
        KIND_UNKNOWN   = 3'd0,
        KIND_LABEL     = 3'd1,
        KIND_LOCAL     = 3'd2,
        KIND_DIRECTIVE = 3'd3,
        KIND_INSTR     = 3'd4,
        KIND_COMMENT   = 3'd5
    } kind_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       final_byte;
    } in_beat_t;

    typedef struct packed {
        logic [OFFSET_BITS-1:0] start_offset;
        logic [OFFSET_BITS-1:0] line_length;
        logic [OFFSET_BITS-1:0] name_offset;
        logic [OFFSET_BITS-1:0] name_length;
        logic [2:0]             line_kind;
        logic                   show_mark;
        logic [31:0]            name_hash;
        logic [NUM_BITS-1:0]    line_number;
        logic                   limit_error;
    } rec_t;

endpackage

// File: rtl/core/alc_scanner.sv
// alc_scanner: per-byte line state, fnv-1a hash and line record build
// depends on alc_pkg; instantiated by asm_line_classifier
module alc_scanner
    import alc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     step,
    input  in_beat_t beat,
    output logic     emit,
    output rec_t     rec
);

    logic [OFFSET_BITS-1:0] pos_reg, pos_next;
    logic [OFFSET_BITS-1:0] line_start_reg, line_start_next;
    phase_t                 phase_reg, phase_next;
    logic [OFFSET_BITS-1:0] name_start_reg, name_start_next;
    logic [OFFSET_BITS-1:0] name_count_reg, name_count_next;
    logic                   starts_local_reg, starts_local_next;
    logic                   starts_dot_reg, starts_dot_next;
    logic [31:0]            hash_reg, hash_next;
    kind_t                  kind_reg, kind_next;
    logic [LINE_BITS-1:0]   lines_reg, lines_next;
    logic                   stopped_reg, stopped_next;

    logic [7:0]             c;
    logic                   eol;
    logic                   is_blank, is_sym, is_first;
    logic [31:0]            hash_mixed;
    logic [NUM_BITS-1:0]    num;
    logic                   lim;

    // multiply by the fnv prime as a sum of shifts
    function automatic logic [31:0] fnv_mul(input logic [31:0] h);
        fnv_mul = h + (h << 1) + (h << 4) + (h << 7) + (h << 8) + (h << 24);
    endfunction

    assign c          = beat.data_byte;
    assign is_blank   = (c == CH_SPACE) || (c == CH_TAB);
    assign is_first   = (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A)
                        || (c == CH_UNDER) || (c == CH_DOT);
    assign is_sym     = is_first || (c >= 8'h30 && c <= 8'h39) || (c == CH_DOLLAR);
    assign hash_mixed = fnv_mul(hash_reg ^ {24'd0, c});

    // phase transitions
    always_comb
    begin
        phase_next = phase_reg;
        eol        = 1'b0;
        unique case (phase_reg)
            PH_INDENT:
            begin
                if (is_blank)
                    phase_next = PH_INDENT;
                else if (is_sym)
                    phase_next = PH_SYMBOL;
                else if (c == CH_SLASH)
                    phase_next = PH_SLASH;
                else if (c == CH_NEWLINE)
                    eol = 1'b1;
                else
                    phase_next = PH_REST;
            end
            PH_SYMBOL:
            begin
                if (is_sym)
                    phase_next = PH_SYMBOL;
                else if (c == CH_NEWLINE)
                    eol = 1'b1;
                else
                    phase_next = PH_REST;
            end
            PH_SLASH:
            begin
                if (c == CH_NEWLINE)
                    eol = 1'b1;
                else
                    phase_next = PH_REST;
            end
            PH_REST:
            begin
                if (c == CH_NEWLINE)
                    eol = 1'b1;
            end
        endcase
    end

    // name, hash and kind updates
    always_comb
    begin
        name_start_next   = name_start_reg;
        name_count_next   = name_count_reg;
        starts_local_next = starts_local_reg;
        starts_dot_next   = starts_dot_reg;
        hash_next         = hash_reg;
        kind_next         = kind_reg;
        unique case (phase_reg)
            PH_INDENT:
            begin
                if (!is_blank)
                begin
                    name_start_next = pos_reg;
                    name_count_next = '0;
                    if (is_sym)
                    begin
                        name_count_next   = {{(OFFSET_BITS-1){1'b0}}, 1'b1};
                        starts_local_next = !is_first;
                        starts_dot_next   = (c == CH_DOT);
                        hash_next         = hash_mixed;
                    end
                    else if (c == CH_HASH)
                        kind_next = KIND_COMMENT;
                end
            end
            PH_SYMBOL:
            begin
                if (is_sym)
                begin
                    name_count_next = name_count_reg + 1'b1;
                    hash_next       = hash_mixed;
                end
                else if (c == CH_COLON)
                    kind_next = starts_local_reg ? KIND_LOCAL : KIND_LABEL;
                else if ((c == CH_NEWLINE) || is_blank)
                begin
                    if ((name_count_reg > 1) && starts_dot_reg)
                    begin
                        kind_next       = KIND_DIRECTIVE;
                        name_start_next = name_start_reg + 1'b1;
                        name_count_next = name_count_reg - 1'b1;
                    end
                    else
                        kind_next = KIND_INSTR;
                end
            end
            PH_SLASH:
            begin
                if (c == CH_SLASH)
                    kind_next = KIND_COMMENT;
            end
            PH_REST:
            begin
                kind_next = kind_reg;
            end
        endcase
    end

    assign num = {1'b0, lines_reg} + 1'b1;
    assign lim = (num >= LINE_MAX);

    always_comb
    begin
        rec.start_offset = line_start_reg;
        rec.line_length  = pos_reg - line_start_reg;
        rec.name_offset  = name_start_next;
        rec.name_length  = name_count_next;
        rec.line_kind    = kind_next;
        rec.show_mark    = (kind_next == KIND_INSTR);
        rec.name_hash    = (kind_next == KIND_LABEL) ? hash_next : 32'd0;
        rec.line_number  = num;
        rec.limit_error  = lim;
    end

    assign emit = step && eol && !stopped_reg;

    assign pos_next        = beat.final_byte ? '0 : pos_reg + 1'b1;
    assign line_start_next = beat.final_byte ? '0 :
                             (eol ? pos_reg + 1'b1 : line_start_reg);

    always_comb
    begin
        lines_next   = lines_reg;
        stopped_next = stopped_reg;
        if (eol && !stopped_reg)
        begin
            if (lim)
                stopped_next = 1'b1;
            else
                lines_next = num[LINE_BITS-1:0];
        end
        if (beat.final_byte)
        begin
            lines_next   = '0;
            stopped_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg          <= '0;
            line_start_reg   <= '0;
            phase_reg        <= PH_INDENT;
            name_start_reg   <= '0;
            name_count_reg   <= '0;
            starts_local_reg <= 1'b0;
            starts_dot_reg   <= 1'b0;
            hash_reg         <= HASH_INIT;
            kind_reg         <= KIND_UNKNOWN;
            lines_reg        <= '0;
            stopped_reg      <= 1'b0;
        end
        else if (step)
        begin
            pos_reg        <= pos_next;
            line_start_reg <= line_start_next;
            lines_reg      <= lines_next;
            stopped_reg    <= stopped_next;
            // a newline or the end of text starts a fresh line
            if (eol || beat.final_byte)
            begin
                phase_reg        <= PH_INDENT;
                name_start_reg   <= '0;
                name_count_reg   <= '0;
                starts_local_reg <= 1'b0;
                starts_dot_reg   <= 1'b0;
                hash_reg         <= HASH_INIT;
                kind_reg         <= KIND_UNKNOWN;
            end
            else
            begin
                phase_reg        <= phase_next;
                name_start_reg   <= name_start_next;
                name_count_reg   <= name_count_next;
                starts_local_reg <= starts_local_next;
                starts_dot_reg   <= starts_dot_next;
                hash_reg         <= hash_next;
                kind_reg         <= kind_next;
            end
        end
    end

endmodule

// File: rtl/core/asm_line_classifier.sv
// asm_line_classifier: top level, byte input channel and line record output
// depends on alc_pkg and alc_scanner
// a record appears at the output register in the cycle after its newline beat is taken
// throughput: one byte per cycle while byte_stall is low; the line state update and hash multiply are combinational
// input stalls only while a record waits in the output register and is itself stalled
// reset: asynchronous active-low reset clears all line state and the output valid flag, not rec_data;
// state also returns to reset values after the beat marked final_byte
module asm_line_classifier
    import alc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     byte_valid,
    output logic     byte_stall,
    input  in_beat_t byte_data,
    output logic     rec_valid,
    input  logic     rec_stall,
    output rec_t     rec_data
);

    logic step;
    logic emit;
    rec_t rec;
    logic rec_valid_reg;
    rec_t rec_data_reg;

    assign byte_stall = rec_valid_reg && rec_stall;
    assign step       = byte_valid && !byte_stall;

    alc_scanner u_scanner (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (step),
        .beat  (byte_data),
        .emit  (emit),
        .rec   (rec)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rec_valid_reg <= 1'b0;
        else if (emit)
            rec_valid_reg <= 1'b1;
        else if (!rec_stall)
            rec_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (emit)
            rec_data_reg <= rec;
    end

    assign rec_valid = rec_valid_reg;
    assign rec_data  = rec_data_reg;

endmodule

// File: tb/sv/testbench.sv
// testbench: self-checking bench for asm_line_classifier, text bytes in, line records out
// depends on alc_pkg and the asm_line_classifier rtl; records are predicted inside the bench
module testbench
    import alc_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    logic     clk;
    logic     rst_n      = 1'b0;
    logic     byte_valid = 1'b0;
    logic     byte_stall;
    in_beat_t byte_data  = '0;
    logic     rec_valid;
    logic     rec_stall  = 1'b0;
    rec_t     rec_data;

    asm_line_classifier u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_stall (byte_stall),
        .byte_data  (byte_data),
        .rec_valid  (rec_valid),
        .rec_stall  (rec_stall),
        .rec_data   (rec_data)
    );

    // line scanner state mirrored by the bench
    logic [OFFSET_BITS-1:0] text_pos;
    logic [OFFSET_BITS-1:0] line_begin;
    logic [OFFSET_BITS-1:0] sym_begin;
    logic [OFFSET_BITS-1:0] sym_count;
    phase_t                 scan_ph;
    logic                   sym_local;
    logic                   sym_dot;
    logic [31:0]            sym_hash;
    kind_t                  line_class;
    logic [LINE_BITS-1:0]   lines_done;
    logic                   records_off;

    rec_t pending_records[$];
    logic [7:0] line_buf[$];

    int  mismatches      = 0;
    int  records_checked = 0;
    int  bytes_sent      = 0;
    int  texts_sent      = 0;
    int  kinds_seen[8];
    bit  idle_on         = 1'b1;
    bit  stall_on        = 1'b1;
    int  hold_left       = 0;

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial begin
        #2_000_000;
        $display("run timed out with %0d records outstanding", pending_records.size());
        $display("CHECK FAILED");
        $finish;
    end

    function automatic bit is_blank(input logic [7:0] c);
        return c == CH_SPACE || c == CH_TAB;
    endfunction

    function automatic bit is_sym(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || (c >= "0" && c <= "9")
            || c == CH_UNDER || c == CH_DOT || c == CH_DOLLAR;
    endfunction

    function automatic void clear_line();
        scan_ph    = PH_INDENT;
        sym_begin  = '0;
        sym_count  = '0;
        sym_local  = 1'b0;
        sym_dot    = 1'b0;
        sym_hash   = HASH_INIT;
        line_class = KIND_UNKNOWN;
    endfunction

    function automatic void restart_text();
        text_pos    = '0;
        line_begin  = '0;
        lines_done  = '0;
        records_off = 1'b0;
        clear_line();
    endfunction

    // advance the line scanner by one byte, queue the record a newline produces
    function automatic void classify_byte(input logic [7:0] c, input logic last_byte);
        logic [OFFSET_BITS-1:0] p;
        logic [NUM_BITS-1:0]    num;
        bit                     eol;
        rec_t                   r;
        p   = text_pos;
        eol = 1'b0;
        case (scan_ph)
            PH_INDENT: begin
                if (!is_blank(c)) begin
                    sym_begin = p;
                    sym_count = '0;
                    if (is_sym(c)) begin
                        scan_ph   = PH_SYMBOL;
                        sym_count = 1;
                        sym_local = (c >= "0" && c <= "9") || c == CH_DOLLAR;
                        sym_dot   = c == CH_DOT;
                        sym_hash  = (sym_hash ^ {24'd0, c}) * HASH_PRIME;
                    end else if (c == CH_HASH) begin
                        line_class = KIND_COMMENT;
                        scan_ph    = PH_REST;
                    end else if (c == CH_SLASH) begin
                        scan_ph = PH_SLASH;
                    end else if (c == CH_NEWLINE) begin
                        eol = 1'b1;
                    end else begin
                        scan_ph = PH_REST;
                    end
                end
            end
            PH_SYMBOL: begin
                if (is_sym(c)) begin
                    sym_count = sym_count + 1;
                    sym_hash  = (sym_hash ^ {24'd0, c}) * HASH_PRIME;
                end else if (c == CH_COLON) begin
                    line_class = sym_local ? KIND_LOCAL : KIND_LABEL;
                    scan_ph    = PH_REST;
                end else if (c == CH_NEWLINE || is_blank(c)) begin
                    // a dot followed by more symbol bytes is a directive, dot dropped
                    if (sym_count > 1 && sym_dot) begin
                        line_class = KIND_DIRECTIVE;
                        sym_begin  = sym_begin + 1;
                        sym_count  = sym_count - 1;
                    end else begin
                        line_class = KIND_INSTR;
                    end
                    if (c == CH_NEWLINE)
                        eol = 1'b1;
                    else
                        scan_ph = PH_REST;
                end else begin
                    scan_ph = PH_REST;
                end
            end
            PH_SLASH: begin
                if (c == CH_SLASH) begin
                    line_class = KIND_COMMENT;
                    scan_ph    = PH_REST;
                end else if (c == CH_NEWLINE) begin
                    eol = 1'b1;
                end else begin
                    scan_ph = PH_REST;
                end
            end
            default: begin
                if (c == CH_NEWLINE)
                    eol = 1'b1;
            end
        endcase

        if (eol) begin
            if (!records_off) begin
                num            = {1'b0, lines_done} + 1'b1;
                r.start_offset = line_begin;
                r.line_length  = p - line_begin;
                r.name_offset  = sym_begin;
                r.name_length  = sym_count;
                r.line_kind    = line_class;
                r.show_mark    = line_class == KIND_INSTR;
                r.name_hash    = (line_class == KIND_LABEL) ? sym_hash : 32'd0;
                r.line_number  = num;
                r.limit_error  = num >= LINE_MAX;
                pending_records.push_back(r);
                if (r.limit_error)
                    records_off = 1'b1;
                else
                    lines_done = num[LINE_BITS-1:0];
            end
            clear_line();
            line_begin = p + 1;
        end
        text_pos = p + 1;
        if (last_byte)
            restart_text();
    endfunction

    task automatic report_mismatch(input string msg);
        if (mismatches < 40)
            $display("mismatch at %0t: %s", $realtime, msg);
        mismatches++;
    endtask

    task automatic check_field(input string field, input logic [31:0] got,
                               input logic [31:0] want, input int num);
        if (got !== want)
            report_mismatch($sformatf("record %0d %s got 0x%0h expected 0x%0h",
                                      num, field, got, want));
    endtask

    // record checker
    initial begin
        rec_t want;
        rec_t got;
        forever begin
            @(posedge clk);
            if (rst_n && rec_valid && !rec_stall) begin
                got = rec_data;
                if (pending_records.size() == 0) begin
                    report_mismatch($sformatf("record with line_number %0d not expected",
                                              got.line_number));
                end else begin
                    want = pending_records.pop_front();
                    check_field("start_offset", got.start_offset, want.start_offset,
                                want.line_number);
                    check_field("line_length", got.line_length, want.line_length,
                                want.line_number);
                    check_field("name_offset", got.name_offset, want.name_offset,
                                want.line_number);
                    check_field("name_length", got.name_length, want.name_length,
                                want.line_number);
                    check_field("line_kind", got.line_kind, want.line_kind, want.line_number);
                    check_field("show_mark", got.show_mark, want.show_mark, want.line_number);
                    check_field("name_hash", got.name_hash, want.name_hash,
                                want.line_number);
                    check_field("line_number", got.line_number, want.line_number,
                                want.line_number);
                    check_field("limit_error", got.limit_error, want.limit_error,
                                want.line_number);
                    records_checked++;
                    kinds_seen[want.line_kind]++;
                end
            end
        end
    end

    // record receiver: random stalls, or a counted hold-off when asked
    initial begin
        forever begin
            @(posedge clk);
            if (hold_left > 0) begin
                rec_stall <= 1'b1;
                hold_left--;
            end else begin
                rec_stall <= stall_on && ($urandom_range(0, 99) < 27);
            end
        end
    end

    task automatic send_byte(input logic [7:0] b, input bit last_byte);
        while (idle_on && $urandom_range(0, 99) < 27) begin
            byte_valid <= 1'b0;
            @(posedge clk);
        end
        byte_valid <= 1'b1;
        byte_data  <= '{data_byte: b, final_byte: last_byte};
        do
            @(posedge clk);
        while (byte_stall);
        classify_byte(b, last_byte);
        bytes_sent++;
        if (last_byte)
            texts_sent++;
    endtask

    task automatic send_str(input string s, input bit last_byte);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i], last_byte && (i == s.len() - 1));
    endtask

    task automatic send_line_buf(input bit last_byte);
        for (int i = 0; i < line_buf.size(); i++)
            send_byte(line_buf[i], last_byte && (i == line_buf.size() - 1));
    endtask

    task automatic wait_drain();
        byte_valid <= 1'b0;
        while (pending_records.size() != 0)
            @(posedge clk);
    endtask

    // first_class: 0 letter or underscore, 1 digit or dollar, 2 dot
    function automatic void put_name(input int first_class, input int len);
        int         r;
        logic [7:0] ch;
        for (int i = 0; i < len; i++) begin
            r = $urandom_range(0, 64);
            if (i == 0 && first_class == 0) begin
                r = $urandom_range(0, 52);
                if (r == 52)
                    r = 62;
            end else if (i == 0 && first_class == 1) begin
                r = $urandom_range(52, 62);
                if (r == 62)
                    r = 64;
            end else if (i == 0) begin
                r = 63;
            end
            if (r < 26)
                ch = "a" + 8'(r);
            else if (r < 52)
                ch = "A" + 8'(r - 26);
            else if (r < 62)
                ch = "0" + 8'(r - 52);
            else if (r == 62)
                ch = CH_UNDER;
            else if (r == 63)
                ch = CH_DOT;
            else
                ch = CH_DOLLAR;
            line_buf.push_back(ch);
        end
    endfunction

    function automatic void put_text(input int len);
        for (int i = 0; i < len; i++) begin
            if ($urandom_range(0, 20) == 0)
                line_buf.push_back(CH_TAB);
            else
                line_buf.push_back(8'($urandom_range(32, 126)));
        end
    endfunction

    // one random line without its newline
    function automatic void build_line();
        int         sel;
        logic [7:0] c;
        line_buf.delete();
        repeat ($urandom_range(0, 3))
            line_buf.push_back($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
        sel = $urandom_range(0, 99);
        if (sel < 22) begin
            put_name(($urandom_range(0, 3) == 0) ? 2 : 0, $urandom_range(1, 8));
            line_buf.push_back(CH_COLON);
            if ($urandom_range(0, 1))
                put_text($urandom_range(0, 8));
        end else if (sel < 32) begin
            put_name(1, $urandom_range(1, 5));
            line_buf.push_back(CH_COLON);
        end else if (sel < 46) begin
            put_name(2, $urandom_range(1, 7));
            if ($urandom_range(0, 1)) begin
                line_buf.push_back($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
                put_text($urandom_range(0, 8));
            end
        end else if (sel < 66) begin
            put_name(0, $urandom_range(1, 6));
            if ($urandom_range(0, 1)) begin
                line_buf.push_back($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
                put_text($urandom_range(0, 10));
            end
        end else if (sel < 74) begin
            line_buf.push_back($urandom_range(0, 1) ? CH_HASH : CH_SLASH);
            if (line_buf[line_buf.size() - 1] == CH_SLASH)
                line_buf.push_back(CH_SLASH);
            put_text($urandom_range(0, 10));
        end else if (sel < 78) begin
            line_buf.push_back(CH_SLASH);
            put_text($urandom_range(0, 4));
        end else if (sel < 84) begin
            // a first byte that opens no symbol, comment or slash
            do
                c = 8'($urandom_range(0, 255));
            while (is_sym(c) || is_blank(c) || c == CH_HASH || c == CH_SLASH
                   || c == CH_NEWLINE);
            line_buf.push_back(c);
            put_text($urandom_range(0, 6));
        end else if (sel < 88) begin
            // symbol run cut short by an odd byte
            put_name(0, $urandom_range(1, 5));
            line_buf.push_back($urandom_range(0, 1) ? 8'($urandom_range(128, 255)) : "(");
            put_text($urandom_range(0, 4));
        end else if (sel >= 93) begin
            repeat ($urandom_range(1, 8))
                line_buf.push_back(8'($urandom_range(0, 255)));
        end
    endfunction

    task automatic test_line_kinds();
        send_str("a:\n", 1'b0);
        send_str("\t$:\n", 1'b0);
        send_str(".b\n", 1'b0);
        send_str(".\n", 1'b0);
        send_str("x\ty\n", 1'b0);
        send_str("#\n", 1'b0);
        send_str("//\n", 1'b0);
        send_str("/\n", 1'b0);
        send_str("a(\n", 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(CH_NEWLINE, 1'b0);
        send_str(" \t\n", 1'b0);
        wait_drain();
    endtask

    task automatic test_text_end();
        // unterminated last lines give nothing, each text restarts at offset zero
        send_str("zz", 1'b1);
        send_str(" \t", 1'b1);
        send_str("k:\n", 1'b1);
        send_str("\n", 1'b1);
        wait_drain();
    endtask

    task automatic test_output_hold();
        idle_on   = 1'b0;
        hold_left = 150;
        repeat (12)
            send_str("op\n", 1'b0);
        wait_drain();
        idle_on = 1'b1;
    endtask

    task automatic test_random_text(input int budget);
        int start;
        int done;
        bit quiet;
        bit held;
        start = bytes_sent;
        held  = 1'b0;
        while (bytes_sent - start < budget) begin
            done     = bytes_sent - start;
            quiet    = done >= budget / 3 && done < budget / 3 + 250;
            idle_on  = !quiet;
            stall_on = !quiet;
            if (!held && done > 2 * budget / 3) begin
                hold_left = $urandom_range(60, 120);
                held      = 1'b1;
            end
            build_line();
            if ($urandom_range(0, 7) != 0) begin
                line_buf.push_back(CH_NEWLINE);
                send_line_buf(1'b0);
            end else begin
                case ($urandom_range(0, 2))
                    0: begin
                        line_buf.push_back(CH_NEWLINE);
                        send_line_buf(1'b1);
                    end
                    1: begin
                        if (line_buf.size() == 0)
                            line_buf.push_back(CH_SPACE);
                        send_line_buf(1'b1);
                    end
                    default: begin
                        line_buf.push_back(CH_NEWLINE);
                        send_line_buf(1'b0);
                        line_buf.delete();
                        repeat ($urandom_range(1, 3))
                            line_buf.push_back($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
                        send_line_buf(1'b1);
                    end
                endcase
            end
            if ($urandom_range(0, 29) == 0)
                wait_drain();
        end
        idle_on  = 1'b1;
        stall_on = 1'b1;
    endtask

    initial begin
        restart_text();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_line_kinds();
        test_text_end();
        test_output_hold();
        test_random_text(875);

        wait_drain();
        repeat (4) @(posedge clk);

        $display("covered %0d bytes over %0d complete texts, %0d line records compared",
                 bytes_sent, texts_sent, records_checked);
        $display("kinds: unknown %0d label %0d local %0d directive %0d instr %0d comment %0d",
                 kinds_seen[KIND_UNKNOWN], kinds_seen[KIND_LABEL], kinds_seen[KIND_LOCAL],
                 kinds_seen[KIND_DIRECTIVE], kinds_seen[KIND_INSTR], kinds_seen[KIND_COMMENT]);
        if (mismatches == 0) begin
            $display("CHECK OK");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
